FILE: rtl/acst_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and microcode table of the audio clock skew tracker
package acst_pkg;

    localparam int FIELD_W     = 48;
    localparam int AVG_W       = 64;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 112;
    localparam int RATE_W      = 19;
    localparam int TICK_W      = 10;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 19;

    localparam logic [RATE_W-1:0]    RATE_RST          = RATE_W'(48000);
    localparam logic [TICK_W-1:0]    TICK_RST          = TICK_W'(10);
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TICK_INTERVAL = CFG_IDX_W'(1);

    // shared divider: dividend left aligned, two quotient bits per cycle
    localparam int DIV_W   = 72;
    localparam int DVS_W   = 19;
    localparam int CNT_W   = 6;
    localparam int MEDIA_W = 58;

    localparam logic [9:0]       MS_PER_S    = 10'd1000;
    localparam logic [DVS_W-1:0] EMA_DEN     = DVS_W'(100);
    localparam logic [7:0]       EMA_KEEP    = 8'd99;
    localparam logic [CNT_W-1:0] MEDIA_STEPS = CNT_W'(MEDIA_W / 2);
    localparam logic [CNT_W-1:0] EMA_STEPS   = CNT_W'(DIV_W / 2);

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_LOAD      = 4'd0;
    localparam logic [PC_W-1:0] PC_CHECK     = 4'd1;
    localparam logic [PC_W-1:0] PC_MEDIA_GO  = 4'd2;
    localparam logic [PC_W-1:0] PC_MEDIA_END = 4'd3;
    localparam logic [PC_W-1:0] PC_SUM       = 4'd4;
    localparam logic [PC_W-1:0] PC_DIFF      = 4'd5;
    localparam logic [PC_W-1:0] PC_MUL       = 4'd6;
    localparam logic [PC_W-1:0] PC_ADD_DQ    = 4'd7;
    localparam logic [PC_W-1:0] PC_EMA_GO    = 4'd8;
    localparam logic [PC_W-1:0] PC_EMA_END   = 4'd9;
    localparam logic [PC_W-1:0] PC_MS        = 4'd10;
    localparam logic [PC_W-1:0] PC_TICK_GO   = 4'd11;
    localparam logic [PC_W-1:0] PC_TICK_END  = 4'd12;
    localparam logic [PC_W-1:0] PC_CORR      = 4'd13;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_MEDIA_GO, OP_MEDIA_END, OP_SUM, OP_DIFF, OP_MUL,
        OP_ADD_DQ, OP_EMA_GO, OP_EMA_END, OP_MS, OP_TICK_GO, OP_TICK_END, OP_CORR
    } t_op;

    typedef enum logic [1:0] {W_NONE, W_IN, W_DIV, W_OUT} t_wait;
    typedef enum logic [1:0] {J_NONE, J_ALWAYS, J_NO_UPD} t_jmp;

    typedef struct packed {
        t_op             op;
        t_wait           wt;
        t_jmp            jc;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic div_busy;
        logic no_upd;
    } t_seq_stat;

    typedef struct packed {
        logic no_upd;
        logic off_valid;
    } t_dp_stat;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [TICK_W-1:0] tick;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic [DIV_W-1:0] quo;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic [AVG_W-1:0]   avg;
        logic [FIELD_W-1:0] corr;
        logic               upd;
    } t_result;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_LOAD:      w = '{OP_LOAD,      W_IN,   J_NONE,   PC_LOAD};
            PC_CHECK:     w = '{OP_NOP,       W_NONE, J_NO_UPD, PC_MS};
            PC_MEDIA_GO:  w = '{OP_MEDIA_GO,  W_NONE, J_NONE,   PC_LOAD};
            PC_MEDIA_END: w = '{OP_MEDIA_END, W_DIV,  J_NONE,   PC_LOAD};
            PC_SUM:       w = '{OP_SUM,       W_NONE, J_NONE,   PC_LOAD};
            PC_DIFF:      w = '{OP_DIFF,      W_NONE, J_NONE,   PC_LOAD};
            PC_MUL:       w = '{OP_MUL,       W_NONE, J_NONE,   PC_LOAD};
            PC_ADD_DQ:    w = '{OP_ADD_DQ,    W_NONE, J_NONE,   PC_LOAD};
            PC_EMA_GO:    w = '{OP_EMA_GO,    W_NONE, J_NONE,   PC_LOAD};
            PC_EMA_END:   w = '{OP_EMA_END,   W_DIV,  J_NONE,   PC_LOAD};
            PC_MS:        w = '{OP_MS,        W_NONE, J_NONE,   PC_LOAD};
            PC_TICK_GO:   w = '{OP_TICK_GO,   W_NONE, J_NONE,   PC_LOAD};
            PC_TICK_END:  w = '{OP_TICK_END,  W_DIV,  J_NONE,   PC_LOAD};
            PC_CORR:      w = '{OP_CORR,      W_OUT,  J_ALWAYS, PC_LOAD};
            default:      w = '{OP_NOP,       W_NONE, J_ALWAYS, PC_LOAD};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/acst_div.sv
`timescale 1ns / 1ps
// shared restoring divider, two quotient bits per cycle
module acst_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  acst_pkg::t_div_req  i_req,
    output acst_pkg::t_div_rsp  o_rsp
);
    import acst_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_t0, w_t1, w_d0, w_d1;
    logic             w_ge0, w_ge1;
    logic [DVS_W-1:0] w_rem0, w_rem1;

    always_comb begin
        w_t0   = {r_rem, r_quo[DIV_W-1]};
        w_d0   = w_t0 - {1'b0, r_dvs};
        w_ge0  = (w_t0 >= {1'b0, r_dvs});
        w_rem0 = w_ge0 ? w_d0[DVS_W-1:0] : w_t0[DVS_W-1:0];
        w_t1   = {w_rem0, r_quo[DIV_W-2]};
        w_d1   = w_t1 - {1'b0, r_dvs};
        w_ge1  = (w_t1 >= {1'b0, r_dvs});
        w_rem1 = w_ge1 ? w_d1[DVS_W-1:0] : w_t1[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-3:0], w_ge0, w_ge1};
            r_rem <= w_rem1;
        end
    end

    assign o_rsp = '{busy: r_busy, quo: r_quo, rem: r_rem};

endmodule

FILE: rtl/acst_seq.sv
`timescale 1ns / 1ps
// microcode sequencer: step counter, wait conditions and jumps
module acst_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  acst_pkg::t_seq_stat  i_stat,
    output acst_pkg::t_ctl       o_ctl,
    output logic                 o_in_ready
);
    import acst_pkg::*;

    logic [PC_W-1:0] r_pc, n_pc;
    t_uword          w_word;
    logic            w_fire, w_jump;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_comb begin
        w_word = ucode(r_pc);
        case (w_word.wt)
            W_IN:    w_fire = i_stat.in_valid;
            W_DIV:   w_fire = !i_stat.div_busy;
            W_OUT:   w_fire = i_stat.out_free;
            default: w_fire = 1'b1;
        endcase
        case (w_word.jc)
            J_ALWAYS: w_jump = 1'b1;
            J_NO_UPD: w_jump = i_stat.no_upd;
            default:  w_jump = 1'b0;
        endcase
        n_pc = r_pc;
        if (w_fire) begin
            n_pc = w_jump ? w_word.target : r_pc + 1'b1;
        end
    end

    assign o_ctl      = '{op: w_word.op, fire: w_fire};
    assign o_in_ready = (w_word.wt == W_IN);

endmodule

FILE: rtl/acst_dp.sv
`timescale 1ns / 1ps
// datapath: media time, offset latch, fixed-point skew average and correction
module acst_dp #(
    parameter int TIME_WIDTH = 48,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  acst_pkg::t_ctl                    i_ctl,
    input  acst_pkg::t_cfg                    i_cfg,
    input  logic [acst_pkg::IN_TDATA_W-1:0]   i_tdata,
    input  acst_pkg::t_div_rsp                i_div,
    output acst_pkg::t_div_req                o_div,
    output acst_pkg::t_dp_stat                o_stat,
    output acst_pkg::t_result                 o_res
);
    import acst_pkg::*;

    localparam int TW     = TIME_WIDTH;
    localparam int SUM_W  = TW + 2;
    localparam int DIFF_W = TW + 3;
    localparam int FIX_W  = AVG_W - FRAC_BITS;
    localparam int MS_E   = FIX_W + (FIX_W % 2);
    localparam int CORR_W = ((TW > FIX_W) ? TW : FIX_W) + 2;
    localparam logic [CNT_W-1:0] TICK_STEPS = CNT_W'(MS_E / 2);
    localparam logic [TW-1:0]    TIME_MAX   = {TW{1'b1}};
    localparam logic [AVG_W-1:0] FRAC_BIAS  = AVG_W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [AVG_W-1:0] FIX_MAX    = {1'b0, {(AVG_W-1){1'b1}}};
    localparam logic [AVG_W-1:0] FIX_MIN    = {1'b1, {(AVG_W-1){1'b0}}};

    // model state
    logic                      r_off_valid;
    logic signed [TW:0]        r_offset;
    logic [FIELD_W-1:0]        r_last;
    logic signed [AVG_W-1:0]   r_avg;
    // per-item scratch
    logic [TW-1:0]             r_wall;
    logic [FIELD_W-1:0]        r_count;
    logic                      r_upd;
    logic [TW-1:0]             r_media;
    logic signed [DIV_W-1:0]   r_acc;
    logic signed [AVG_W-1:0]   r_dq;
    logic                      r_neg;
    logic signed [FIX_W-1:0]   r_ms;
    logic signed [FIX_W-1:0]   r_round;

    logic [TW-1:0]             w_wall;
    logic [FIELD_W-1:0]        w_count;
    logic                      w_upd;
    logic [MEDIA_W-1:0]        w_prod;
    logic [DVS_W-1:0]          w_rate, w_tick;
    logic [TW-1:0]             w_media;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [DIV_W-1:0]   w_diff_x;
    logic [DIV_W-FIX_W:0]      w_hi;
    logic [AVG_W-1:0]          w_dq;
    logic signed [DIV_W-1:0]   w_mul, w_add;
    logic [DIV_W-1:0]          w_mag, w_avg_n;
    logic signed [AVG_W-1:0]   w_biased;
    logic [FIX_W-1:0]          w_ms_mag, w_rem_x;
    logic signed [FIX_W-1:0]   w_round;
    logic signed [CORR_W-1:0]  w_wall_c, w_round_c, w_corr;
    logic [TW-1:0]             w_corr_sat;

    always_comb begin
        w_wall  = TW'(i_tdata[FIELD_W-1:0]);
        w_count = i_tdata[IN_TDATA_W-1:FIELD_W];
        w_upd   = (w_count > r_last) || !r_off_valid;
        w_prod  = MEDIA_W'(r_count) * MEDIA_W'(MS_PER_S);
        w_rate  = (i_cfg.rate == '0) ? DVS_W'(1) : DVS_W'(i_cfg.rate);
        w_tick  = (i_cfg.tick == '0) ? DVS_W'(1) : DVS_W'(i_cfg.tick);
        // media time saturates to the time range
        w_media = (|i_div.quo[MEDIA_W-1:TW]) ? TIME_MAX : i_div.quo[TW-1:0];
        w_sum   = $signed({2'b00, r_media}) + $signed({r_offset[TW], r_offset});
        w_diff  = $signed({3'b000, r_wall}) - $signed(r_acc[DIFF_W-1:0]);
        w_diff_x = DIV_W'(w_diff);
        w_hi    = w_diff_x[DIV_W-1:FIX_W-1];
        if ((&w_hi) || !(|w_hi)) begin
            w_dq = {w_diff_x[FIX_W-1:0], {FRAC_BITS{1'b0}}};
        end else begin
            w_dq = w_diff_x[DIV_W-1] ? FIX_MIN : FIX_MAX;
        end
        w_mul   = DIV_W'(r_avg) * $signed(EMA_KEEP);
        w_add   = r_acc + DIV_W'(r_dq);
        w_mag   = r_acc[DIV_W-1] ? -r_acc : r_acc;
        // floor for negative sums: -(q + (rem != 0))
        w_avg_n = r_neg ? (~i_div.quo + DIV_W'(i_div.rem == '0)) : i_div.quo;
        // truncate toward zero to whole ms
        w_biased = r_avg + $signed(r_avg[AVG_W-1] ? FRAC_BIAS : '0);
        w_ms_mag = r_ms[FIX_W-1] ? -r_ms : r_ms;
        w_rem_x  = FIX_W'(i_div.rem);
        w_round  = r_neg ? (r_ms + $signed(w_rem_x)) : (r_ms - $signed(w_rem_x));
        w_wall_c  = CORR_W'($signed({1'b0, r_wall}));
        w_round_c = CORR_W'(r_round);
        w_corr    = w_wall_c - w_round_c;
        if (w_corr[CORR_W-1]) begin
            w_corr_sat = '0;
        end else if (|w_corr[CORR_W-2:TW]) begin
            w_corr_sat = TIME_MAX;
        end else begin
            w_corr_sat = w_corr[TW-1:0];
        end
    end

    always_comb begin
        o_div.start    = 1'b0;
        o_div.dividend = '0;
        o_div.divisor  = EMA_DEN;
        o_div.steps    = EMA_STEPS;
        case (i_ctl.op)
            OP_MEDIA_GO: begin
                o_div.start    = i_ctl.fire;
                o_div.dividend = DIV_W'(w_prod) << (DIV_W - MEDIA_W);
                o_div.divisor  = w_rate;
                o_div.steps    = MEDIA_STEPS;
            end
            OP_EMA_GO: begin
                o_div.start    = i_ctl.fire;
                o_div.dividend = w_mag;
            end
            OP_TICK_GO: begin
                o_div.start    = i_ctl.fire;
                o_div.dividend = DIV_W'(w_ms_mag) << (DIV_W - MS_E);
                o_div.divisor  = w_tick;
                o_div.steps    = TICK_STEPS;
            end
            default: begin
                o_div.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_valid <= 1'b0;
            r_offset    <= '0;
            r_last      <= '0;
            r_avg       <= '0;
        end else if (i_ctl.fire) begin
            case (i_ctl.op)
                OP_MEDIA_END: begin
                    r_last <= r_count;
                    if (!r_off_valid) begin
                        r_offset    <= $signed({1'b0, r_wall}) - $signed({1'b0, w_media});
                        r_off_valid <= 1'b1;
                    end
                end
                OP_EMA_END: r_avg <= w_avg_n[AVG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire) begin
            case (i_ctl.op)
                OP_LOAD: begin
                    r_wall  <= w_wall;
                    r_count <= w_count;
                    r_upd   <= w_upd;
                end
                OP_MEDIA_END: r_media <= w_media;
                OP_SUM:       r_acc   <= DIV_W'(w_sum);
                OP_DIFF:      r_dq    <= w_dq;
                OP_MUL:       r_acc   <= w_mul;
                OP_ADD_DQ:    r_acc   <= w_add;
                OP_EMA_GO:    r_neg   <= r_acc[DIV_W-1];
                OP_MS:        r_ms    <= w_biased[AVG_W-1:FRAC_BITS];
                OP_TICK_GO:   r_neg   <= r_ms[FIX_W-1];
                OP_TICK_END:  r_round <= w_round;
                default: ;
            endcase
        end
    end

    assign o_stat = '{no_upd: !r_upd, off_valid: r_off_valid};
    assign o_res  = '{avg: r_avg, corr: FIELD_W'(w_corr_sat), upd: r_upd};

endmodule

FILE: rtl/audio_clock_skew_tracker_core.sv
`timescale 1ns / 1ps
// top level of the audio clock skew tracker
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+-----------------------------------
//  s_axis   | in  | s_axis_tvalid/tready       | tdata: wall_ms, sample_count
//  m_axis   | out | m_axis_tvalid/tready       | tdata: avg_skew_q16, corrected_ms;
//           |     |                            | tuser: skew_updated
//  cfg      | in  | i_cfg_valid/o_cfg_ready    | i_cfg_index, i_cfg_data
//
// one beat at a time through a microcoded datapath with one shared divider that
// retires two quotient bits per cycle; a beat that updates the average runs three divisions
// (media time, average and tick rounding), one that does not runs only the tick division;
// the tick division runs over MS_E = 64 - FRAC_BITS bits, rounded up to even
// synchronous active-low reset clears the offset, count and average and loads the
// register defaults; no clearing pass is needed
// a stalled result sits in the output register while the next beat is taken in
module audio_clock_skew_tracker_core #(
    parameter int TIME_WIDTH = 48,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // wall_ms [47:0], sample_count [95:48]
    input  logic [acst_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // avg_skew_q16 [63:0], corrected_ms [111:64]
    output logic [acst_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // skew_updated [0]
    output logic                                 m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [acst_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [acst_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import acst_pkg::*;

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_result   r_out;

    t_ctl      w_ctl;
    t_seq_stat w_seq_stat;
    t_dp_stat  w_dp_stat;
    t_div_req  w_div_req;
    t_div_rsp  w_div_rsp;
    t_result   w_res;
    logic      w_out_free, w_out_load;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_out_load = w_ctl.fire && (w_ctl.op == OP_CORR);
    assign w_seq_stat = '{in_valid: s_axis_tvalid, out_free: w_out_free,
                          div_busy: w_div_rsp.busy, no_upd: w_dp_stat.no_upd};

    acst_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_seq_stat),
        .o_ctl      (w_ctl),
        .o_in_ready (s_axis_tready)
    );

    acst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    acst_dp #(
        .TIME_WIDTH (TIME_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_cfg   (r_cfg),
        .i_tdata (s_axis_tdata),
        .i_div   (w_div_rsp),
        .o_div   (w_div_req),
        .o_stat  (w_dp_stat),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate <= RATE_RST;
            r_cfg.tick <= TICK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SAMPLE_RATE:   r_cfg.rate <= i_cfg_data[RATE_W-1:0];
                REG_TICK_INTERVAL: r_cfg.tick <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_res;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.corr, r_out.avg};
    assign m_axis_tuser  = r_out.upd;

    // sequencer leaves the load step right after taking a beat
    a_load_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still ready after a beat was taken");

    // every division has finished before the next beat comes in
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_div_rsp.busy)
        else $error("divider busy while waiting for input");

    // any result follows a beat that latched the offset
    a_offset_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> w_dp_stat.off_valid)
        else $error("result without a latched offset");

endmodule
